// ===== hw/rtl/ats_pkg.sv =====
// ----------------------------------------------------------------------------
// ats_pkg
// Shared constants, codes and control types of the alias table sampler.
// ----------------------------------------------------------------------------
`default_nettype none

package ats_pkg;

    // Default values of the top level parameters.
    localparam int DEF_NUM_ROWS    = 16;
    localparam int DEF_NUM_COLUMNS = 64;
    localparam int DEF_WEIGHT_BITS = 16;

    // Fixed widths of the port fields.
    localparam int MODE_W     = 2;
    localparam int ROW_F_W    = 4;
    localparam int COL_F_W    = 6;
    localparam int WEIGHT_F_W = 16;
    localparam int FRAC_W     = 16;
    localparam int SAMPLE_W   = 6;
    localparam int NORM_OUT_W = 22;

    // Item modes.
    localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DRAW   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_NORM   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    // What an accepted item asks of the block.
    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_DRAW,
        KIND_NORM,
        KIND_BUILD
    } t_kind;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic clear_wr;
        logic cnt_rst;
        logic cnt_inc;
        logic sum_rd;
        logic scan_rd;
        logic norm_wr;
        logic pop;
        logic get_pair;
        logic get_sps;
        logic reduce;
        logic out_load;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_kind kind;
        logic  cnt_last_col;
        logic  cnt_last_all;
        logic  pairs_left;
        logic  out_free;
    } t_sts;

endpackage

`default_nettype wire

// ===== hw/rtl/ats_ram.sv =====
// ----------------------------------------------------------------------------
// ats_ram
// Generic simple dual port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module ats_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== hw/rtl/ats_ctrl.sv =====
// ----------------------------------------------------------------------------
// ats_ctrl
// Sequencer of the alias table sampler: clearing, item decode, table build.
// ----------------------------------------------------------------------------
`default_nettype none

module ats_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire ats_pkg::t_sts i_sts,
    output ats_pkg::t_cmd      o_cmd
);

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SUM,
        ST_SCAN,
        ST_SCAN_END,
        ST_PAIR_POP,
        ST_PAIR_GET,
        ST_PAIR_SPS,
        ST_PAIR_RED,
        ST_OUT
    } t_state;

    t_state        r_state;
    t_state        n_state;
    ats_pkg::t_cmd n_cmd;

    always_comb begin
        n_state = r_state;
        n_cmd   = '0;
        unique case (r_state)
            ST_CLEAR: begin
                n_cmd.clear_wr = 1'b1;
                n_cmd.cnt_inc  = 1'b1;
                if (i_sts.cnt_last_all) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_valid) begin
                    n_cmd.accept  = 1'b1;
                    n_cmd.cnt_rst = 1'b1;
                    if (i_sts.kind == ats_pkg::KIND_BUILD) begin
                        n_state = ST_SUM;
                    end else begin
                        n_state = ST_OUT;
                    end
                end
            end
            ST_SUM: begin
                n_cmd.sum_rd = 1'b1;
                if (i_sts.cnt_last_col) begin
                    n_cmd.cnt_rst = 1'b1;
                    n_state       = ST_SCAN;
                end else begin
                    n_cmd.cnt_inc = 1'b1;
                end
            end
            ST_SCAN: begin
                n_cmd.scan_rd = 1'b1;
                n_cmd.norm_wr = 1'b1;
                if (i_sts.cnt_last_col) begin
                    n_cmd.cnt_rst = 1'b1;
                    n_state       = ST_SCAN_END;
                end else begin
                    n_cmd.cnt_inc = 1'b1;
                end
            end
            ST_SCAN_END: begin
                n_state = ST_PAIR_POP;
            end
            ST_PAIR_POP: begin
                if (i_sts.pairs_left) begin
                    n_cmd.pop = 1'b1;
                    n_state   = ST_PAIR_GET;
                end else begin
                    n_state = ST_OUT;
                end
            end
            ST_PAIR_GET: begin
                n_cmd.get_pair = 1'b1;
                n_state        = ST_PAIR_SPS;
            end
            ST_PAIR_SPS: begin
                n_cmd.get_sps = 1'b1;
                n_state       = ST_PAIR_RED;
            end
            ST_PAIR_RED: begin
                n_cmd.reduce = 1'b1;
                n_state      = ST_PAIR_POP;
            end
            ST_OUT: begin
                if (i_sts.out_free) begin
                    n_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd   = n_cmd;
    assign o_ready = (r_state == ST_IDLE);

endmodule

`default_nettype wire

// ===== hw/rtl/ats_dp.sv =====
// ----------------------------------------------------------------------------
// ats_dp
// Datapath of the alias table sampler: table memories, stacks and arithmetic.
// ----------------------------------------------------------------------------
`default_nettype none

module ats_dp #(
    parameter int NUM_ROWS    = ats_pkg::DEF_NUM_ROWS,
    parameter int NUM_COLUMNS = ats_pkg::DEF_NUM_COLUMNS,
    parameter int WEIGHT_BITS = ats_pkg::DEF_WEIGHT_BITS
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire ats_pkg::t_cmd                     i_cmd,
    output ats_pkg::t_sts                          o_sts,
    input  wire logic [ats_pkg::MODE_W-1:0]        i_mode,
    input  wire logic [ats_pkg::ROW_F_W-1:0]       i_row,
    input  wire logic [ats_pkg::COL_F_W-1:0]       i_column,
    input  wire logic [ats_pkg::WEIGHT_F_W-1:0]    i_weight,
    input  wire logic                              i_build_now,
    input  wire logic [ats_pkg::COL_F_W-1:0]       i_random_column,
    input  wire logic [ats_pkg::FRAC_W-1:0]        i_random_fraction,
    output logic                                   o_valid,
    input  wire logic                              i_ready,
    output logic      [ats_pkg::SAMPLE_W-1:0]      o_sample,
    output logic      [ats_pkg::NORM_OUT_W-1:0]    o_norm_value,
    output logic                                   o_table_built
);

    localparam int COL_W  = $clog2(NUM_COLUMNS);
    localparam int ROW_W  = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
    localparam int ADDR_W = ROW_W + COL_W;
    localparam int DEPTH  = 1 << ADDR_W;
    localparam int NORM_W = WEIGHT_BITS + COL_W;
    localparam int CNT_W  = $clog2(NUM_COLUMNS + 1);
    localparam int PROD_W = NORM_W + ats_pkg::FRAC_W;
    localparam int RCOL_N = 1 << ats_pkg::COL_F_W;

    // Input decode.
    logic                row_ok;
    logic                col_ok;
    logic                load_wr;
    ats_pkg::t_kind      kind_in;
    logic [ROW_W-1:0]    in_row;
    logic [COL_W-1:0]    in_col;
    logic [COL_W-1:0]    in_dcol;
    logic [COL_W-1:0]    mod_tab [RCOL_N];

    // Registers.
    ats_pkg::t_kind      r_kind;
    logic [ROW_W-1:0]    r_row;
    logic [COL_W-1:0]    r_dcol;
    logic [ats_pkg::FRAC_W-1:0] r_frac;
    logic [ADDR_W-1:0]   r_cnt;
    logic [NORM_W-1:0]   r_acc;
    logic                r_sum_v;
    logic                r_scan_v;
    logic [COL_W-1:0]    r_col_d;
    logic [CNT_W-1:0]    r_sc;
    logic [CNT_W-1:0]    r_lc;
    logic [COL_W-1:0]    r_l;
    logic [NORM_W-1:0]   r_sp_s;
    logic                r_o_valid;
    logic [ats_pkg::SAMPLE_W-1:0]   r_o_sample;
    logic [ats_pkg::NORM_OUT_W-1:0] r_o_norm;
    logic                r_o_built;

    // Memory ports.
    logic                   w_we, w_re;
    logic [ADDR_W-1:0]      w_waddr, w_raddr;
    logic [WEIGHT_BITS-1:0] w_wdata, w_rdata;
    logic                   sp_we, sp_re;
    logic [ADDR_W-1:0]      sp_waddr, sp_raddr;
    logic [NORM_W-1:0]      sp_rdata;
    logic                   al_we;
    logic [ADDR_W-1:0]      al_waddr, al_raddr;
    logic [COL_W-1:0]       al_wdata, al_rdata;
    logic                   nm_we;
    logic [ROW_W-1:0]       nm_waddr;
    logic [NORM_W-1:0]      nm_wdata, nm_rdata;
    logic                   ss_we, ls_we;
    logic [COL_W-1:0]       ss_raddr, ls_raddr;
    logic [COL_W-1:0]       ss_rdata, ls_rdata;

    // Build arithmetic.
    logic [COL_W-1:0]  cnt_col;
    logic [CNT_W-1:0]  sc_dec, lc_dec;
    logic [NORM_W-1:0] scan_sp, red_sp, push_val;
    logic [COL_W-1:0]  push_col;
    logic              push_en, push_small;
    logic [PROD_W-1:0] lhs, rhs;
    logic [COL_W-1:0]  draw_sample;

    for (genvar g = 0; g < RCOL_N; g++) begin : g_mod
        assign mod_tab[g] = COL_W'(g % NUM_COLUMNS);
    end

    assign row_ok  = 32'(i_row) < NUM_ROWS;
    assign col_ok  = 32'(i_column) < NUM_COLUMNS;
    assign in_row  = ROW_W'(i_row);
    assign in_col  = COL_W'(i_column);
    assign in_dcol = mod_tab[i_random_column];
    assign load_wr = i_cmd.accept && row_ok && col_ok && (i_mode == ats_pkg::MODE_LOAD);

    always_comb begin
        unique case (i_mode)
            ats_pkg::MODE_LOAD: kind_in = i_build_now ? ats_pkg::KIND_BUILD
                                                      : ats_pkg::KIND_NORM;
            ats_pkg::MODE_DRAW: kind_in = ats_pkg::KIND_DRAW;
            ats_pkg::MODE_NORM: kind_in = ats_pkg::KIND_NORM;
            default:            kind_in = ats_pkg::KIND_NONE;
        endcase
        if (!row_ok) begin
            kind_in = ats_pkg::KIND_NONE;
        end
    end

    assign cnt_col = r_cnt[COL_W-1:0];
    assign sc_dec  = r_sc - CNT_W'(1);
    assign lc_dec  = r_lc - CNT_W'(1);

    // Scaling by the column count, and the pair reduction.
    assign scan_sp    = NORM_W'(w_rdata) * NORM_W'(NUM_COLUMNS);
    assign red_sp     = sp_rdata - (r_acc - r_sp_s);
    assign push_en    = r_scan_v || i_cmd.reduce;
    assign push_col   = r_scan_v ? r_col_d : r_l;
    assign push_val   = r_scan_v ? scan_sp : red_sp;
    assign push_small = push_val < r_acc;

    // Weight buffer.
    assign w_we    = i_cmd.clear_wr || load_wr;
    assign w_waddr = i_cmd.clear_wr ? r_cnt : {in_row, in_col};
    assign w_wdata = i_cmd.clear_wr ? '0 : WEIGHT_BITS'(i_weight);
    assign w_re    = i_cmd.sum_rd || i_cmd.scan_rd;
    assign w_raddr = {r_row, cnt_col};

    // Scaled values.
    assign sp_we    = push_en;
    assign sp_waddr = {r_row, push_col};
    assign sp_re    = i_cmd.accept || i_cmd.get_pair || i_cmd.get_sps;
    always_comb begin
        if (i_cmd.accept) begin
            sp_raddr = {in_row, in_dcol};
        end else if (i_cmd.get_pair) begin
            sp_raddr = {r_row, ss_rdata};
        end else begin
            sp_raddr = {r_row, r_l};
        end
    end

    // Aliases.
    assign al_we    = i_cmd.clear_wr || i_cmd.get_pair;
    assign al_waddr = i_cmd.clear_wr ? r_cnt : {r_row, ss_rdata};
    assign al_wdata = i_cmd.clear_wr ? '0 : ls_rdata;
    assign al_raddr = {in_row, in_dcol};

    // Row norms.
    assign nm_we    = i_cmd.clear_wr || i_cmd.norm_wr;
    assign nm_waddr = i_cmd.clear_wr ? r_cnt[ADDR_W-1:COL_W] : r_row;
    assign nm_wdata = i_cmd.clear_wr ? '0 : r_acc;

    // Stacks.
    assign ss_we    = push_en && push_small && (r_sc < CNT_W'(NUM_COLUMNS));
    assign ls_we    = push_en && !push_small && (r_lc < CNT_W'(NUM_COLUMNS));
    assign ss_raddr = sc_dec[COL_W-1:0];
    assign ls_raddr = lc_dec[COL_W-1:0];

    ats_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(DEPTH)) u_weight_ram (
        .i_clk(i_clk), .i_wr_en(w_we), .i_wr_addr(w_waddr), .i_wr_data(w_wdata),
        .i_rd_en(w_re), .i_rd_addr(w_raddr), .o_rd_data(w_rdata)
    );

    ats_ram #(.WIDTH(NORM_W), .DEPTH(DEPTH)) u_scaled_ram (
        .i_clk(i_clk), .i_wr_en(sp_we), .i_wr_addr(sp_waddr), .i_wr_data(push_val),
        .i_rd_en(sp_re), .i_rd_addr(sp_raddr), .o_rd_data(sp_rdata)
    );

    ats_ram #(.WIDTH(COL_W), .DEPTH(DEPTH)) u_alias_ram (
        .i_clk(i_clk), .i_wr_en(al_we), .i_wr_addr(al_waddr), .i_wr_data(al_wdata),
        .i_rd_en(i_cmd.accept), .i_rd_addr(al_raddr), .o_rd_data(al_rdata)
    );

    ats_ram #(.WIDTH(NORM_W), .DEPTH(1 << ROW_W)) u_norm_ram (
        .i_clk(i_clk), .i_wr_en(nm_we), .i_wr_addr(nm_waddr), .i_wr_data(nm_wdata),
        .i_rd_en(i_cmd.accept), .i_rd_addr(in_row), .o_rd_data(nm_rdata)
    );

    ats_ram #(.WIDTH(COL_W), .DEPTH(NUM_COLUMNS)) u_small_stack (
        .i_clk(i_clk), .i_wr_en(ss_we), .i_wr_addr(r_sc[COL_W-1:0]),
        .i_wr_data(push_col), .i_rd_en(i_cmd.pop), .i_rd_addr(ss_raddr),
        .o_rd_data(ss_rdata)
    );

    ats_ram #(.WIDTH(COL_W), .DEPTH(NUM_COLUMNS)) u_large_stack (
        .i_clk(i_clk), .i_wr_en(ls_we), .i_wr_addr(r_lc[COL_W-1:0]),
        .i_wr_data(push_col), .i_rd_en(i_cmd.pop), .i_rd_addr(ls_raddr),
        .o_rd_data(ls_rdata)
    );

    // Draw: keep the column when fraction times norm lies below its scaled value.
    assign lhs         = PROD_W'(r_frac) * PROD_W'(nm_rdata);
    assign rhs         = {sp_rdata, {ats_pkg::FRAC_W{1'b0}}};
    assign draw_sample = (lhs < rhs) ? r_dcol : al_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_sum_v   <= 1'b0;
            r_scan_v  <= 1'b0;
            r_sc      <= '0;
            r_lc      <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_sum_v  <= i_cmd.sum_rd;
            r_scan_v <= i_cmd.scan_rd;
            if (i_cmd.cnt_rst) begin
                r_cnt <= '0;
            end else if (i_cmd.cnt_inc) begin
                r_cnt <= r_cnt + ADDR_W'(1);
            end
            if (i_cmd.accept) begin
                r_sc <= '0;
                r_lc <= '0;
            end else if (i_cmd.pop) begin
                r_sc <= sc_dec;
                r_lc <= lc_dec;
            end else begin
                if (ss_we) begin
                    r_sc <= r_sc + CNT_W'(1);
                end
                if (ls_we) begin
                    r_lc <= r_lc + CNT_W'(1);
                end
            end
            if (i_cmd.out_load) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_col_d <= cnt_col;
        if (i_cmd.accept) begin
            r_kind <= kind_in;
            r_row  <= in_row;
            r_dcol <= in_dcol;
            r_frac <= i_random_fraction;
            r_acc  <= '0;
        end else if (r_sum_v) begin
            r_acc <= r_acc + NORM_W'(w_rdata);
        end
        if (i_cmd.get_pair) begin
            r_l <= ls_rdata;
        end
        if (i_cmd.get_sps) begin
            r_sp_s <= sp_rdata;
        end
        if (i_cmd.out_load) begin
            case (r_kind)
                ats_pkg::KIND_DRAW: begin
                    r_o_sample <= ats_pkg::SAMPLE_W'(draw_sample);
                    r_o_norm   <= ats_pkg::NORM_OUT_W'(nm_rdata);
                    r_o_built  <= 1'b0;
                end
                ats_pkg::KIND_NORM: begin
                    r_o_sample <= '0;
                    r_o_norm   <= ats_pkg::NORM_OUT_W'(nm_rdata);
                    r_o_built  <= 1'b0;
                end
                ats_pkg::KIND_BUILD: begin
                    r_o_sample <= '0;
                    r_o_norm   <= ats_pkg::NORM_OUT_W'(r_acc);
                    r_o_built  <= 1'b1;
                end
                default: begin
                    r_o_sample <= '0;
                    r_o_norm   <= '0;
                    r_o_built  <= 1'b0;
                end
            endcase
        end
    end

    assign o_sts.kind         = kind_in;
    assign o_sts.cnt_last_col = (cnt_col == COL_W'(NUM_COLUMNS - 1));
    assign o_sts.cnt_last_all = &r_cnt;
    assign o_sts.pairs_left   = (r_sc != '0) && (r_lc != '0);
    assign o_sts.out_free     = !r_o_valid || i_ready;

    assign o_valid       = r_o_valid;
    assign o_sample      = r_o_sample;
    assign o_norm_value  = r_o_norm;
    assign o_table_built = r_o_built;

endmodule

`default_nettype wire

// ===== hw/rtl/alias_table_sampler.sv =====
// ----------------------------------------------------------------------------
// alias_table_sampler
// Alias method sampler over several weighted rows, with table build on load.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake            Payload
//  --------  -------------------  ---------------------------------------------
//  input     i_valid / o_ready    mode, row, column, weight, build_now,
//                                 random_column, random_fraction
//  output    o_valid / i_ready    sample, norm_value, table_built
//
// A draw, a norm read or a load without build is taken in the idle state,
// which issues the memory reads; the result is formed in the output state.
// A build walks the columns twice over the single read port of the weight
// buffer, then runs the four-step pair loop around the scaled value memory
// (pairs is at most NUM_COLUMNS-1).
// After reset a clearing pass zeroes the weight, alias and norm memories over
// 2^(row bits + column bits) addresses (1024 by default); o_ready stays low.
// A new transaction is taken while a result waits on a stalled output; the
// next result then waits until the output register frees.
//
`default_nettype none

module alias_table_sampler #(
    parameter int NUM_ROWS    = ats_pkg::DEF_NUM_ROWS,
    parameter int NUM_COLUMNS = ats_pkg::DEF_NUM_COLUMNS,
    parameter int WEIGHT_BITS = ats_pkg::DEF_WEIGHT_BITS
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_ready,
    input  wire logic [ats_pkg::MODE_W-1:0]        i_mode,
    input  wire logic [ats_pkg::ROW_F_W-1:0]       i_row,
    input  wire logic [ats_pkg::COL_F_W-1:0]       i_column,
    input  wire logic [ats_pkg::WEIGHT_F_W-1:0]    i_weight,
    input  wire logic                              i_build_now,
    input  wire logic [ats_pkg::COL_F_W-1:0]       i_random_column,
    input  wire logic [ats_pkg::FRAC_W-1:0]        i_random_fraction,
    output logic                                   o_valid,
    input  wire logic                              i_ready,
    output logic      [ats_pkg::SAMPLE_W-1:0]      o_sample,
    output logic      [ats_pkg::NORM_OUT_W-1:0]    o_norm_value,
    output logic                                   o_table_built
);

    // The controller sequences the work; the datapath holds all storage.
    ats_pkg::t_cmd cmd;
    ats_pkg::t_sts sts;

    ats_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    ats_dp #(
        .NUM_ROWS    (NUM_ROWS),
        .NUM_COLUMNS (NUM_COLUMNS),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_mode            (i_mode),
        .i_row             (i_row),
        .i_column          (i_column),
        .i_weight          (i_weight),
        .i_build_now       (i_build_now),
        .i_random_column   (i_random_column),
        .i_random_fraction (i_random_fraction),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_sample          (o_sample),
        .o_norm_value      (o_norm_value),
        .o_table_built     (o_table_built)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/ats_checker.sv =====
// ----------------------------------------------------------------------------
// ats_checker
// Port level checks of the alias table sampler, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ats_checker (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           i_valid,
    input wire logic                           o_ready,
    input wire logic                           o_valid,
    input wire logic                           i_ready,
    input wire logic [ats_pkg::SAMPLE_W-1:0]   o_sample,
    input wire logic [ats_pkg::NORM_OUT_W-1:0] o_norm_value,
    input wire logic                           o_table_built
);

    logic       in_acc;
    logic       out_acc;
    logic [1:0] r_pending;

    assign in_acc  = i_valid && o_ready;
    assign out_acc = o_valid && i_ready;

    // Transactions taken in but not yet delivered.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= r_pending + 2'(in_acc) - 2'(out_acc);
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_sample) && $stable(o_norm_value)
                               && $stable(o_table_built))
        else $error("result changed while stalled");

    a_built_no_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_table_built |-> o_sample == '0)
        else $error("build result carries a sample");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !o_ready)
        else $error("second transaction taken while one is in work");

    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc |-> r_pending != 2'd0)
        else $error("result delivered without a pending transaction");

endmodule

bind alias_table_sampler ats_checker u_ats_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_ready       (o_ready),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_sample      (o_sample),
    .o_norm_value  (o_norm_value),
    .o_table_built (o_table_built)
);

`default_nettype wire

// ===== sim/alias_table_sampler_test.sv =====
// ----------------------------------------------------------------------------
// alias_table_sampler_test
// Self-checking regression of the alias table sampler: loads, builds, draws
// and norm reads are predicted in the bench and compared result by result.
// ----------------------------------------------------------------------------
`default_nettype none

module alias_table_sampler_test;

    localparam int ROWS  = ats_pkg::DEF_NUM_ROWS;
    localparam int COLS  = ats_pkg::DEF_NUM_COLUMNS;

    // Clock, reset and the two channels of the block.
    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_valid;
    logic                            o_ready;
    logic [ats_pkg::MODE_W-1:0]      i_mode;
    logic [ats_pkg::ROW_F_W-1:0]     i_row;
    logic [ats_pkg::COL_F_W-1:0]     i_column;
    logic [ats_pkg::WEIGHT_F_W-1:0]  i_weight;
    logic                            i_build_now;
    logic [ats_pkg::COL_F_W-1:0]     i_random_column;
    logic [ats_pkg::FRAC_W-1:0]      i_random_fraction;
    logic                            o_valid;
    logic                            i_ready;
    logic [ats_pkg::SAMPLE_W-1:0]    o_sample;
    logic [ats_pkg::NORM_OUT_W-1:0]  o_norm_value;
    logic                            o_table_built;

    alias_table_sampler u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_mode            (i_mode),
        .i_row             (i_row),
        .i_column          (i_column),
        .i_weight          (i_weight),
        .i_build_now       (i_build_now),
        .i_random_column   (i_random_column),
        .i_random_fraction (i_random_fraction),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_sample          (o_sample),
        .o_norm_value      (o_norm_value),
        .o_table_built     (o_table_built)
    );

    // One expected result of a transaction.
    typedef struct {
        logic [ats_pkg::SAMPLE_W-1:0]   sample;
        logic [ats_pkg::NORM_OUT_W-1:0] norm;
        logic                           built;
    } t_outcome;

    // The bench's own image of the sampler state. Scaled values are kept
    // wide so that intermediate sums never wrap.
    logic [ats_pkg::WEIGHT_F_W-1:0] weights   [ROWS][COLS];
    logic [31:0]                    scaled    [ROWS][COLS];
    logic [ats_pkg::COL_F_W-1:0]    aliases   [ROWS][COLS];
    logic [31:0]                    row_norms [ROWS];
    bit                             row_built [ROWS];

    t_outcome pending_outcomes[$];
    int       error_count;
    int       sent_count;
    int       checked_count;
    int       draws_sent;
    int       builds_sent;
    bit       ready_idle_on;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Generous cut-off: it stays well above the run even if every one of about
    // 1000 items were a full build with the longest gaps and stalls on both
    // sides.
    initial begin
        #10000000;
        $display("alias_table_sampler regression: fail");
        $finish;
    end

    // Walker/Vose build of one row, mirroring the block's stack order.
    function automatic void rebuild_row(input int r);
        logic [31:0] total;
        int          small_stk [COLS];
        int          large_stk [COLS];
        int          n_small;
        int          n_large;
        int          s;
        int          l;
        total   = 0;
        n_small = 0;
        n_large = 0;
        for (int c = 0; c < COLS; c++) total += weights[r][c];
        row_norms[r] = total;
        for (int c = 0; c < COLS; c++) begin
            scaled[r][c] = weights[r][c] * COLS;
            if (scaled[r][c] < total) small_stk[n_small++] = c;
            else                      large_stk[n_large++] = c;
        end
        while (n_small > 0 && n_large > 0) begin
            s = small_stk[--n_small];
            l = large_stk[--n_large];
            aliases[r][s] = ats_pkg::COL_F_W'(l);
            scaled[r][l] = scaled[r][l] - (total - scaled[r][s]);
            if (scaled[r][l] < total) small_stk[n_small++] = l;
            else                      large_stk[n_large++] = l;
        end
        row_built[r] = 1'b1;
    endfunction

    function automatic t_outcome predict_outcome(
        input logic [ats_pkg::MODE_W-1:0] mode, input int r, input int col,
        input logic [ats_pkg::WEIGHT_F_W-1:0] w, input bit build, input int rcol,
        input logic [ats_pkg::FRAC_W-1:0] frac);
        t_outcome    o;
        logic [47:0] lhs;
        logic [47:0] rhs;
        o = '{sample: '0, norm: '0, built: 1'b0};
        if (mode == ats_pkg::MODE_LOAD) begin
            weights[r][col] = w;
            if (build) begin
                rebuild_row(r);
                o.built = 1'b1;
            end
        end else if (mode == ats_pkg::MODE_DRAW) begin
            lhs = 48'(frac) * 48'(row_norms[r]);
            rhs = 48'(scaled[r][rcol]) << 16;
            o.sample = (lhs < rhs) ? ats_pkg::COL_F_W'(rcol) : aliases[r][rcol];
        end
        if (mode != ats_pkg::MODE_UNUSED) o.norm = row_norms[r][ats_pkg::NORM_OUT_W-1:0];
        return o;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int gap_length();
        if ($urandom_range(0, 99) < 60) return 0;
        if ($urandom_range(0, 99) < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Sends one transaction and records what it must produce. Inputs move
    // on the falling edge; acceptance is seen at the rising edge.
    task automatic send_item(input logic [ats_pkg::MODE_W-1:0] mode, input int r,
                             input int col, input logic [ats_pkg::WEIGHT_F_W-1:0] w,
                             input bit build, input int rcol,
                             input logic [ats_pkg::FRAC_W-1:0] frac);
        int gap;
        gap = gap_length();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid           <= 1'b1;
        i_mode            <= mode;
        i_row             <= ats_pkg::ROW_F_W'(r);
        i_column          <= ats_pkg::COL_F_W'(col);
        i_weight          <= w;
        i_build_now       <= build;
        i_random_column   <= ats_pkg::COL_F_W'(rcol);
        i_random_fraction <= frac;
        do @(posedge i_clk); while (!o_ready);
        pending_outcomes.push_back(predict_outcome(mode, r, col, w, build, rcol, frac));
        sent_count++;
        if (mode == ats_pkg::MODE_DRAW) draws_sent++;
        if (mode == ats_pkg::MODE_LOAD && build) builds_sent++;
        @(negedge i_clk);
    endtask

    // Result side: checks each accepted result against the oldest one due.
    initial begin
        t_outcome want;
        forever begin
            @(posedge i_clk);
            if (o_valid && i_ready) begin
                if (pending_outcomes.size() == 0) begin
                    $display("%0t: unexpected result sample=%0d norm=%0d built=%0b",
                             $time, o_sample, o_norm_value, o_table_built);
                    error_count++;
                end else begin
                    want = pending_outcomes.pop_front();
                    checked_count++;
                    if (o_sample !== want.sample) begin
                        $display("%0t: sample expected %0d actual %0d",
                                 $time, want.sample, o_sample);
                        error_count++;
                    end
                    if (o_norm_value !== want.norm) begin
                        $display("%0t: norm_value expected %0d actual %0d",
                                 $time, want.norm, o_norm_value);
                        error_count++;
                    end
                    if (o_table_built !== want.built) begin
                        $display("%0t: table_built expected %0b actual %0b",
                                 $time, want.built, o_table_built);
                        error_count++;
                    end
                end
            end
        end
    end

    // Receiver stalls, switched off for some stretches of the run.
    initial begin
        int hold;
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!ready_idle_on) begin
                i_ready <= 1'b1;
            end else begin
                hold = gap_length();
                if (hold > 0) begin
                    i_ready <= 1'b0;
                    repeat (hold) @(negedge i_clk);
                end
                i_ready <= 1'b1;
            end
        end
    end

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Fills a whole row with weights from a chosen pattern and builds it.
    // Pattern 0 is random, 1 all zero, 2 all maximum, 3 one heavy column,
    // 4 small random values.
    task automatic load_row(input int r, input int pattern);
        logic [ats_pkg::WEIGHT_F_W-1:0] w;
        for (int c = 0; c < COLS; c++) begin
            case (pattern)
                0: w = ats_pkg::WEIGHT_F_W'($urandom);
                1: w = '0;
                2: w = '1;
                3: w = (c == 5) ? 16'hFFFF : 16'd0;
                default: w = ats_pkg::WEIGHT_F_W'($urandom_range(0, 7));
            endcase
            send_item(ats_pkg::MODE_LOAD, r, c, w, c == COLS - 1, 0, 16'(0));
        end
    endtask

    // Directed part: field extremes and each special case.
    task automatic test_directed();
        ready_idle_on = 1'b0;
        // Norm read of an untouched row, unused mode, loads without build.
        send_item(ats_pkg::MODE_NORM, 0, 0, 16'h0, 1'b0, 0, 16'h0);
        send_item(ats_pkg::MODE_UNUSED, 15, 63, 16'hFFFF, 1'b1, 63, 16'hFFFF);
        send_item(ats_pkg::MODE_LOAD, 15, 63, 16'hFFFF, 1'b0, 63, 16'hFFFF);
        send_item(ats_pkg::MODE_LOAD, 15, 0, 16'h0001, 1'b0, 0, 16'h0);
        // Zero-norm row: build with only zero weights, then draw from it.
        send_item(ats_pkg::MODE_LOAD, 3, 0, 16'h0, 1'b1, 0, 16'h0);
        row_built[3] = 1'b1;
        send_item(ats_pkg::MODE_DRAW, 3, 0, 16'h0, 1'b0, 0, 16'h0);
        send_item(ats_pkg::MODE_DRAW, 3, 0, 16'hFFFF, 1'b0, 63, 16'hFFFF);
        // Build row 15 (three nonzero weights) and draw at the extremes.
        send_item(ats_pkg::MODE_LOAD, 15, 10, 16'h8000, 1'b1, 0, 16'h0);
        send_item(ats_pkg::MODE_DRAW, 15, 0, 16'h0, 1'b0, 0, 16'h0);
        send_item(ats_pkg::MODE_DRAW, 15, 0, 16'h0, 1'b0, 63, 16'hFFFF);
        send_item(ats_pkg::MODE_DRAW, 15, 0, 16'h0, 1'b0, 10, 16'h7FFF);
        send_item(ats_pkg::MODE_NORM, 15, 0, 16'h0, 1'b0, 0, 16'h0);
        wait_drained();
    endtask

    // Whole-row builds with extreme and random weight patterns.
    task automatic test_row_builds();
        ready_idle_on = 1'b1;
        load_row(1, 2);
        load_row(2, 3);
        load_row(4, 1);
        load_row(0, 0);
        for (int k = 0; k < 8; k++) send_item(ats_pkg::MODE_DRAW, 2, 0, 16'h0, 1'b0,
            $urandom_range(0, 63), 16'($urandom));
        // Sender holds off until every expected result has arrived.
        wait_drained();
    endtask

    // Random traffic: draws on built rows, norm reads on any row, single-column
    // updates with or without a rebuild, and occasional unused-mode noise.
    task automatic test_random_traffic();
        int                             r;
        int                             pick;
        logic [ats_pkg::WEIGHT_F_W-1:0] w;
        for (int n = 0; n < 700; n++) begin
            ready_idle_on = (n / 150) % 2 == 0;
            pick = $urandom_range(0, 99);
            r = $urandom_range(0, ROWS - 1);
            w = ($urandom_range(0, 3) == 0) ? ats_pkg::WEIGHT_F_W'($urandom)
                                             : ats_pkg::WEIGHT_F_W'($urandom_range(0, 255));
            if (pick < 55) begin
                while (!row_built[r]) r = $urandom_range(0, ROWS - 1);
                send_item(ats_pkg::MODE_DRAW, r, $urandom_range(0, 63), w,
                          $urandom_range(0, 1), $urandom_range(0, 63), 16'($urandom));
            end else if (pick < 65) begin
                send_item(ats_pkg::MODE_NORM, r, $urandom_range(0, 63), w,
                          $urandom_range(0, 1), $urandom_range(0, 63), 16'($urandom));
            end else if (pick < 90) begin
                send_item(ats_pkg::MODE_LOAD, r, $urandom_range(0, 63), w, 1'b0,
                          $urandom_range(0, 63), 16'($urandom));
            end else if (pick < 96) begin
                send_item(ats_pkg::MODE_LOAD, r, $urandom_range(0, 63), w, 1'b1,
                          $urandom_range(0, 63), 16'($urandom));
            end else begin
                send_item(ats_pkg::MODE_UNUSED, r, $urandom_range(0, 63), w,
                          $urandom_range(0, 1), $urandom_range(0, 63), 16'($urandom));
            end
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_mode = ats_pkg::MODE_LOAD;
        i_row = '0;
        i_column = '0;
        i_weight = '0;
        i_build_now = 1'b0;
        i_random_column = '0;
        i_random_fraction = '0;
        ready_idle_on = 1'b0;
        error_count = 0;
        sent_count = 0;
        checked_count = 0;
        draws_sent = 0;
        builds_sent = 0;
        for (int r = 0; r < ROWS; r++) begin
            row_norms[r] = 0;
            row_built[r] = 1'b0;
            for (int c = 0; c < COLS; c++) begin
                weights[r][c] = '0;
                scaled[r][c]  = 0;
                aliases[r][c] = '0;
            end
        end
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_row_builds();
        test_random_traffic();

        wait_drained();
        repeat (20) @(posedge i_clk);
        $display("Covered %0d transactions (%0d draws, %0d builds), %0d results checked.",
                 sent_count, draws_sent, builds_sent, checked_count);
        if (error_count == 0 && pending_outcomes.size() == 0) begin
            $display("alias_table_sampler regression: pass");
        end else begin
            $display("alias_table_sampler regression: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
hw/rtl/ats_pkg.sv
hw/rtl/ats_ram.sv
hw/rtl/ats_ctrl.sv
hw/rtl/ats_dp.sv
hw/rtl/alias_table_sampler.sv
hw/rtl/ats_checker.sv
sim/alias_table_sampler_test.sv
